FILE: hw/rtl/gsp_pkg.sv
// ============================================================================
// gsp_pkg: shared types and constants of the gas sensor ppm pipeline
// Widths, fixed-point constants and the stage-to-stage records.
// ============================================================================
package gsp_pkg;

    localparam int ADC_BITS   = 12;
    localparam int MV_W       = 13;
    localparam int OHM_W      = 24;
    localparam int COEF_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_TDATA_W = ((ADC_BITS + 7) / 8) * 8;

    // a = adc * vref and s = supply << ADC_BITS share one width.
    localparam int A_W        = ADC_BITS + MV_W;
    localparam int PROD_W     = A_W + OHM_W;
    localparam int CMP_W      = PROD_W + 4;
    localparam int EXP_W      = $clog2(PROD_W);
    localparam int MANT_W     = 31;
    localparam int FRAC_BITS  = 20;
    localparam int COEF_FRAC  = 12;

    localparam int LR_W       = EXP_W + FRAC_BITS + 1;
    localparam int MAG_W      = EXP_W + FRAC_BITS + COEF_FRAC + 1;
    localparam int NUMER_W    = MAG_W + 1;
    localparam int REM_W      = COEF_W + 1;
    localparam int SH_W       = 6;
    localparam int N_TERMS    = 14;

    localparam int L10_Q20    = 3483294;
    localparam int LN2_Q30    = 744261118;
    localparam int ONE_Q30    = 1 << 30;
    localparam int LOW_LIM    = 10 << ADC_BITS;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_LOW = 2'd1,
        ST_SAT = 2'd2
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_R0     = 3'd0,
        CFG_RL     = 3'd1,
        CFG_VREF   = 3'd2,
        CFG_SUPPLY = 3'd3,
        CFG_SLOPE  = 3'd4,
        CFG_ICEPT  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [OHM_W-1:0]  r0;
        logic [OHM_W-1:0]  rl;
        logic [MV_W-1:0]   vref;
        logic [MV_W-1:0]   supply;
        logic              slope_zero;
    } t_cfg;

    // An item whose result is already known rides along with done set.
    typedef struct packed {
        logic    done;
        t_status status;
    } t_flag;

    typedef struct packed {
        t_flag            flag;
        logic             clamp_lo;
        logic             clamp_hi;
        logic [EXP_W-1:0] n_num;
        logic [EXP_W-1:0] n_den;
    } t_lmeta;

    typedef struct packed {
        t_flag flag;
        logic  neg;
    } t_dmeta;

    typedef struct packed {
        t_flag             flag;
        logic [SH_W-1:0]   sh;
        logic [29:0]       x;
        logic [MANT_W-1:0] term;
        logic [31:0]       sum;
    } t_exs;

endpackage

FILE: hw/rtl/gsp_front.sv
// ============================================================================
// gsp_front: voltage, resistance products, clamps and log2 normalization
// Five stages: sample, a = adc * vref, num/den products, clamp compares with
// leading-one search, and mantissa normalization to Q30.
// ============================================================================
module gsp_front
    import gsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [ADC_BITS-1:0] i_adc,
    input  t_cfg                i_cfg,
    output logic                o_valid,
    output t_lmeta              o_meta,
    output logic [MANT_W-1:0]   o_mant_num,
    output logic [MANT_W-1:0]   o_mant_den
);

    function automatic logic [EXP_W-1:0] msb_pos(input logic [PROD_W-1:0] x);
        logic [EXP_W-1:0] p;
        p = '0;
        for (int i = 0; i < PROD_W; i++) begin
            if (x[i]) p = EXP_W'(i);
        end
        return p;
    endfunction

    logic                r1_v, r2_v, r3_v, r4_v, r5_v;
    logic [ADC_BITS-1:0] r1_adc;
    logic [A_W-1:0]      r2_a;
    logic [PROD_W-1:0]   r3_num, r3_den, r4_num, r4_den;
    t_flag               r3_flag;
    t_lmeta              r4_meta, r5_meta;
    logic [MANT_W-1:0]   r5_mn, r5_md;

    logic [A_W-1:0]      s_mv;
    logic                low;

    assign s_mv = A_W'(i_cfg.supply) << ADC_BITS;
    assign low  = (r2_a <= A_W'(LOW_LIM)) || (i_cfg.r0 == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_adc <= i_adc;
            r2_a   <= A_W'(r1_adc) * A_W'(i_cfg.vref);

            // Supply at or below v gives a non-positive Rs; num = 0 forces the low clamp.
            r3_num <= (s_mv > r2_a) ? PROD_W'(i_cfg.rl) * PROD_W'(s_mv - r2_a) : '0;
            r3_den <= PROD_W'(r2_a) * PROD_W'(i_cfg.r0);
            r3_flag.done   <= low || i_cfg.slope_zero;
            r3_flag.status <= low ? ST_LOW : ST_SAT;

            r4_num <= r3_num;
            r4_den <= r3_den;
            r4_meta.flag     <= r3_flag;
            r4_meta.clamp_lo <= (CMP_W'(r3_num) * CMP_W'(10)) <= CMP_W'(r3_den);
            r4_meta.clamp_hi <= CMP_W'(r3_num) >= (CMP_W'(r3_den) * CMP_W'(10));
            r4_meta.n_num    <= msb_pos(r3_num);
            r4_meta.n_den    <= msb_pos(r3_den);

            r5_meta <= r4_meta;
            r5_mn   <= MANT_W'({r4_num, 30'b0} >> r4_meta.n_num);
            r5_md   <= MANT_W'({r4_den, 30'b0} >> r4_meta.n_den);
        end
    end

    assign o_valid    = r5_v;
    assign o_meta     = r5_meta;
    assign o_mant_num = r5_mn;
    assign o_mant_den = r5_md;

endmodule

FILE: hw/rtl/gsp_log2.sv
// ============================================================================
// gsp_log2: fraction bits of log2 for numerator and denominator
// One squaring stage per fraction bit, most significant bit first.
// ============================================================================
module gsp_log2
    import gsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_lmeta               i_meta,
    input  logic [MANT_W-1:0]    i_mant_num,
    input  logic [MANT_W-1:0]    i_mant_den,
    output logic                 o_valid,
    output t_lmeta               o_meta,
    output logic [FRAC_BITS-1:0] o_frac_num,
    output logic [FRAC_BITS-1:0] o_frac_den
);

    // Square in Q30; a result of 2.0 or more yields a one bit and is halved.
    function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     m2;
        sq = (2*MANT_W)'(m) * (2*MANT_W)'(m);
        m2 = sq[2*MANT_W-1:30];
        if (m2[MANT_W]) return {1'b1, m2[MANT_W:1]};
        else            return {1'b0, m2[MANT_W-1:0]};
    endfunction

    logic                 r_v  [FRAC_BITS];
    t_lmeta               r_meta [FRAC_BITS];
    logic [MANT_W-1:0]    r_mn [FRAC_BITS];
    logic [MANT_W-1:0]    r_md [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_fn [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_fd [FRAC_BITS];

    for (genvar j = 0; j < FRAC_BITS; j++) begin : g_st
        logic                 v_in;
        t_lmeta               meta_in;
        logic [MANT_W-1:0]    mn_in, md_in;
        logic [FRAC_BITS-1:0] fn_in, fd_in;
        logic [MANT_W:0]      sn, sd;

        if (j == 0) begin : g_head
            assign v_in    = i_valid;
            assign meta_in = i_meta;
            assign mn_in   = i_mant_num;
            assign md_in   = i_mant_den;
            assign fn_in   = '0;
            assign fd_in   = '0;
        end else begin : g_body
            assign v_in    = r_v[j-1];
            assign meta_in = r_meta[j-1];
            assign mn_in   = r_mn[j-1];
            assign md_in   = r_md[j-1];
            assign fn_in   = r_fn[j-1];
            assign fd_in   = r_fd[j-1];
        end

        assign sn = sq_step(mn_in);
        assign sd = sq_step(md_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_meta[j] <= meta_in;
                r_mn[j]   <= sn[MANT_W-1:0];
                r_md[j]   <= sd[MANT_W-1:0];
                r_fn[j]   <= {fn_in[FRAC_BITS-2:0], sn[MANT_W]};
                r_fd[j]   <= {fd_in[FRAC_BITS-2:0], sd[MANT_W]};
            end
        end
    end

    assign o_valid    = r_v[FRAC_BITS-1];
    assign o_meta     = r_meta[FRAC_BITS-1];
    assign o_frac_num = r_fn[FRAC_BITS-1];
    assign o_frac_den = r_fd[FRAC_BITS-1];

endmodule

FILE: hw/rtl/gsp_div.sv
// ============================================================================
// gsp_div: exponent numerator and pipelined division by the slope
// Forms lr * 2^12 - b * log2(10), then a restoring divider of one quotient
// bit per stage on magnitudes, truncating toward zero.
// ============================================================================
module gsp_div
    import gsp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  t_lmeta                    i_meta,
    input  logic [FRAC_BITS-1:0]      i_frac_num,
    input  logic [FRAC_BITS-1:0]      i_frac_den,
    input  logic signed [NUMER_W-1:0] i_bl10,
    input  logic [COEF_W-1:0]         i_mdiv,
    input  logic                      i_mneg,
    output logic                      o_valid,
    output t_dmeta                    o_meta,
    output logic [MAG_W-1:0]          o_quot
);

    localparam int DW = REM_W + MAG_W;
    localparam logic signed [LR_W-1:0] L10_LR = LR_W'(L10_Q20);

    logic signed [LR_W-1:0]    lr;
    logic signed [NUMER_W-1:0] numer;

    always_comb begin
        if (i_meta.clamp_lo)      lr = -L10_LR;
        else if (i_meta.clamp_hi) lr = L10_LR;
        else lr = $signed({1'b0, i_meta.n_num, i_frac_num})
                - $signed({1'b0, i_meta.n_den, i_frac_den});
        numer = (NUMER_W'(lr) <<< COEF_FRAC) - i_bl10;
    end

    logic         r0_v;
    t_dmeta       r0_meta;
    logic [DW-1:0] r0_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_meta.flag <= i_meta.flag;
            r0_meta.neg  <= numer[NUMER_W-1] ^ i_mneg;
            r0_w <= DW'(MAG_W'(numer[NUMER_W-1] ? -numer : numer));
        end
    end

    // The work word holds the partial remainder above the shifting dividend.
    logic          r_v    [MAG_W];
    t_dmeta        r_meta [MAG_W];
    logic [DW-1:0] r_w    [MAG_W];

    for (genvar j = 0; j < MAG_W; j++) begin : g_st
        logic          v_in;
        t_dmeta        meta_in;
        logic [DW-1:0] w_in, w_nx;
        logic [REM_W-1:0] hi;

        if (j == 0) begin : g_head
            assign v_in    = r0_v;
            assign meta_in = r0_meta;
            assign w_in    = r0_w;
        end else begin : g_body
            assign v_in    = r_v[j-1];
            assign meta_in = r_meta[j-1];
            assign w_in    = r_w[j-1];
        end

        always_comb begin
            w_nx = {w_in[DW-2:0], 1'b0};
            hi   = w_nx[DW-1:MAG_W];
            if (hi >= REM_W'(i_mdiv)) begin
                w_nx[DW-1:MAG_W] = hi - REM_W'(i_mdiv);
                w_nx[0]          = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_meta[j] <= meta_in;
                r_w[j]    <= w_nx;
            end
        end
    end

    assign o_valid = r_v[MAG_W-1];
    assign o_meta  = r_meta[MAG_W-1];
    assign o_quot  = r_w[MAG_W-1][MAG_W-1:0];

endmodule

FILE: hw/rtl/gsp_exp2.sv
// ============================================================================
// gsp_exp2: power of two of the exponent and output rounding
// Range checks, series argument, fourteen Taylor terms of three stages each
// (multiply, reciprocal divide, correct and accumulate), then shift and round.
// ============================================================================
module gsp_exp2
    import gsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_dmeta           i_meta,
    input  logic [MAG_W-1:0] i_quot,
    output logic             o_valid,
    output logic [31:0]      o_ppm,
    output t_status          o_status
);

    localparam int F_W = NUMER_W + 1;
    localparam logic signed [F_W-1:0] F_OFS   = F_W'(8 << FRAC_BITS);
    localparam logic signed [F_W-1:0] F_HI    = F_W'(32 << FRAC_BITS);
    localparam logic signed [F_W-1:0] F_LO    = -F_W'(1 << FRAC_BITS);
    localparam logic signed [F_W-1:0] F_ONE   = F_W'(1 << FRAC_BITS);

    // Stage A: signed exponent, range checks, integer and fraction split.
    logic signed [NUMER_W-1:0] e;
    logic signed [F_W-1:0]     f, g;
    t_flag                     fa;

    always_comb begin
        e = i_meta.neg ? -$signed(NUMER_W'(i_quot)) : $signed(NUMER_W'(i_quot));
        f = F_W'(e) + F_OFS;
        g = f + F_ONE;
        fa = i_meta.flag;
        if (!fa.done) begin
            if (f >= F_HI) begin
                fa.done   = 1'b1;
                fa.status = ST_SAT;
            end else if (f < F_LO) begin
                fa.done   = 1'b1;
                fa.status = ST_OK;
            end
        end
    end

    logic                 ra_v, rb_v;
    t_flag                ra_flag;
    logic [FRAC_BITS-1:0] ra_fr;
    logic [SH_W-1:0]      ra_sh;
    t_exs                 rb_s;
    logic [FRAC_BITS+29:0] xp;

    assign xp = (FRAC_BITS+30)'(ra_fr) * (FRAC_BITS+30)'(LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
            rb_v <= 1'b0;
        end else if (i_en) begin
            ra_v <= i_valid;
            rb_v <= ra_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_flag <= fa;
            ra_fr   <= g[FRAC_BITS-1:0];
            ra_sh   <= g[FRAC_BITS+SH_W-1:FRAC_BITS];

            rb_s.flag <= ra_flag;
            rb_s.sh   <= ra_sh;
            rb_s.x    <= xp[FRAC_BITS+29:FRAC_BITS];
            rb_s.term <= MANT_W'(ONE_Q30);
            rb_s.sum  <= 32'(ONE_Q30);
        end
    end

    logic        r_cv [N_TERMS];
    t_exs        r_cs [N_TERMS];

    for (genvar j = 0; j < N_TERMS; j++) begin : g_term
        localparam int K = j + 1;
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

        logic              v_in;
        t_exs              s_in;
        logic              r_pv, r_qv;
        t_exs              r_ps, r_qs;
        logic [60:0]       r_prod;
        logic [MANT_W-1:0] r_t, r_q0;
        logic [63:0]       tr;
        logic [34:0]       qk;
        logic [MANT_W-1:0] rr, q;
        t_exs              s_nx;

        if (j == 0) begin : g_head
            assign v_in = rb_v;
            assign s_in = rb_s;
        end else begin : g_body
            assign v_in = r_cv[j-1];
            assign s_in = r_cs[j-1];
        end

        // Division by K as a reciprocal multiply, low by at most one.
        assign tr = 64'(r_prod[60:30]) * 64'(RECIP);
        assign qk = 35'(r_q0) * 35'(K);
        assign rr = r_t - qk[MANT_W-1:0];
        assign q  = (rr >= MANT_W'(K)) ? r_q0 + MANT_W'(1) : r_q0;

        always_comb begin
            s_nx      = r_qs;
            s_nx.term = q;
            s_nx.sum  = r_qs.sum + 32'(q);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv    <= 1'b0;
                r_qv    <= 1'b0;
                r_cv[j] <= 1'b0;
            end else if (i_en) begin
                r_pv    <= v_in;
                r_qv    <= r_pv;
                r_cv[j] <= r_qv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ps    <= s_in;
                r_prod  <= 61'(s_in.term) * 61'(s_in.x);
                r_qs    <= r_ps;
                r_t     <= r_prod[60:30];
                r_q0    <= tr[62:32];
                r_cs[j] <= s_nx;
            end
        end
    end

    // Final stage: scale by the integer part and round half up into Q24.8.
    t_exs        sf;
    logic [64:0] pk;
    logic [33:0] ppm_w;
    logic        r_fv;
    logic [31:0] r_ppm;
    t_status     r_status;

    assign sf    = r_cs[N_TERMS-1];
    assign pk    = (65'(sf.sum) << sf.sh) + 65'(ONE_Q30);
    assign ppm_w = pk[64:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv <= r_cv[N_TERMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (sf.flag.done) begin
                r_ppm    <= (sf.flag.status == ST_SAT) ? '1 : '0;
                r_status <= sf.flag.status;
            end else if (ppm_w[33:32] != 2'b00) begin
                r_ppm    <= '1;
                r_status <= ST_SAT;
            end else begin
                r_ppm    <= ppm_w[31:0];
                r_status <= ST_OK;
            end
        end
    end

    assign o_valid  = r_fv;
    assign o_ppm    = r_ppm;
    assign o_status = r_status;

endmodule

FILE: hw/rtl/gas_sensor_adc_to_ppm_top.sv
// Throughput: one item per cycle while the skid stage is empty; the 39-stage
// slope divider and the 14-term exp2 series (three stages per term) set the
// pipeline depth.
// A two-entry output register and skid stage hold results while the sink stalls.
// Reset (synchronous, active low) empties the pipeline and loads default registers.
// ============================================================================
// gas_sensor_adc_to_ppm_top: ADC sample to gas concentration in ppm
// Configuration registers, pipeline stages and the output handshake.
// ============================================================================
module gas_sensor_adc_to_ppm_top
    import gsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,   // [11:0] adc_sample, rest zero
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [31:0]           o_m_axis_tdata,   // [31:0] ppm_q8
    output logic [1:0]            o_m_axis_tuser,   // [1:0] status
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [OHM_W-1:0]      i_cfg_wdata
);

    logic [OHM_W-1:0]         r_r0, r_rl;
    logic [MV_W-1:0]          r_vref, r_supply;
    logic signed [COEF_W-1:0] r_slope, r_icept;
    logic signed [NUMER_W-1:0] r_bl10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0     <= OHM_W'(1000);
            r_rl     <= OHM_W'(10000);
            r_vref   <= MV_W'(3300);
            r_supply <= MV_W'(3300);
            r_slope  <= -COEF_W'(1843);
            r_icept  <= COEF_W'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_R0:     r_r0     <= i_cfg_wdata;
                CFG_RL:     r_rl     <= i_cfg_wdata;
                CFG_VREF:   r_vref   <= i_cfg_wdata[MV_W-1:0];
                CFG_SUPPLY: r_supply <= i_cfg_wdata[MV_W-1:0];
                CFG_SLOPE:  r_slope  <= i_cfg_wdata[COEF_W-1:0];
                CFG_ICEPT:  r_icept  <= i_cfg_wdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Intercept term b * log2(10), refreshed every cycle from the register.
    always_ff @(posedge i_clk) begin
        r_bl10 <= NUMER_W'(r_icept) * NUMER_W'(L10_Q20);
    end

    t_cfg             cfg;
    logic [COEF_W-1:0] mdiv;

    assign cfg.r0         = r_r0;
    assign cfg.rl         = r_rl;
    assign cfg.vref       = r_vref;
    assign cfg.supply     = r_supply;
    assign cfg.slope_zero = (r_slope == '0);
    assign mdiv           = r_slope[COEF_W-1] ? COEF_W'(-r_slope) : COEF_W'(r_slope);

    logic                 en;
    logic                 fr_v, lg_v, dv_v, ex_v;
    t_lmeta               fr_meta, lg_meta;
    logic [MANT_W-1:0]    fr_mn, fr_md;
    logic [FRAC_BITS-1:0] lg_fn, lg_fd;
    t_dmeta               dv_meta;
    logic [MAG_W-1:0]     dv_q;
    logic [31:0]          ex_ppm;
    t_status              ex_status;

    logic                 r_out_valid, r_skid_valid;
    logic [31:0]          r_out_ppm, r_skid_ppm;
    t_status              r_out_status, r_skid_status;
    logic                 take;

    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;

    gsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_s_axis_tvalid),
        .i_adc      (i_s_axis_tdata[ADC_BITS-1:0]),
        .i_cfg      (cfg),
        .o_valid    (fr_v),
        .o_meta     (fr_meta),
        .o_mant_num (fr_mn),
        .o_mant_den (fr_md)
    );

    gsp_log2 u_log2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (fr_v),
        .i_meta     (fr_meta),
        .i_mant_num (fr_mn),
        .i_mant_den (fr_md),
        .o_valid    (lg_v),
        .o_meta     (lg_meta),
        .o_frac_num (lg_fn),
        .o_frac_den (lg_fd)
    );

    gsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (lg_v),
        .i_meta     (lg_meta),
        .i_frac_num (lg_fn),
        .i_frac_den (lg_fd),
        .i_bl10     (r_bl10),
        .i_mdiv     (mdiv),
        .i_mneg     (r_slope[COEF_W-1]),
        .o_valid    (dv_v),
        .o_meta     (dv_meta),
        .o_quot     (dv_q)
    );

    gsp_exp2 u_exp2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (dv_v),
        .i_meta   (dv_meta),
        .i_quot   (dv_q),
        .o_valid  (ex_v),
        .o_ppm    (ex_ppm),
        .o_status (ex_status)
    );

    assign take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_ppm    <= r_skid_ppm;
                r_out_status <= r_skid_status;
                r_skid_valid <= 1'b0;
            end
        end else if (ex_v) begin
            if (!r_out_valid || take) begin
                r_out_ppm    <= ex_ppm;
                r_out_status <= ex_status;
                r_out_valid  <= 1'b1;
            end else begin
                r_skid_ppm    <= ex_ppm;
                r_skid_status <= ex_status;
                r_skid_valid  <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_ppm;
    assign o_m_axis_tuser  = r_out_status;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output item");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready && ex_v && !r_skid_valid) |=> r_skid_valid)
        else $error("finished item dropped while output stalled");

    a_low_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_LOW)) |-> (o_m_axis_tdata == '0))
        else $error("low signal item with nonzero ppm");

    a_sat_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_SAT)) |-> (o_m_axis_tdata == '1))
        else $error("saturated item without full-scale ppm");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the ADC sample to ppm converter
// Samples are streamed in under random idling. A fixed-point predictor
// queues the expected ppm and status for each accepted item, and a monitor
// compares every output item with the oldest entry in that queue.
// ============================================================================
module tb;
    import gsp_pkg::*;

    localparam int LATENCY = 111;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_TDATA_W-1:0] s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [31:0]           m_data;
    logic [1:0]            m_user;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [OHM_W-1:0]      cfg_wdata = '0;

    logic [23:0] r0_reg, rl_reg;
    logic [12:0] vref_reg, supply_reg;
    logic signed [15:0] slope_reg, icept_reg;

    typedef struct packed {
        logic [31:0] ppm;
        logic [1:0]  status;
    } t_ppm_res;

    t_ppm_res pending_ppm[$];
    int  n_errors = 0;
    bit  calm = 1'b0;

    always #1 i_clk = ~i_clk;

    gas_sensor_adc_to_ppm_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata)
    );

    function automatic longint log2_fix(longint unsigned x);
        int n;
        longint unsigned mant;
        longint unsigned frac;
        n = 0;
        frac = 0;
        while (n < 63 && (x >> (n + 1)) != 0) n++;
        if (n >= 30) mant = x >> (n - 30);
        else mant = x << (30 - n);
        for (int k = FRAC_BITS - 1; k >= 0; k--) begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd1 << 31)) begin
                mant >>= 1;
                frac |= 64'd1 << k;
            end
        end
        return longint'((64'(n) << FRAC_BITS) | frac);
    endfunction

    function automatic longint unsigned pow2_frac(longint unsigned fr);
        longint unsigned x, term, sum;
        x = (fr * 64'd744261118) >> FRAC_BITS;
        term = 64'd1 << 30;
        sum = term;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * x) >> 30) / k;
            sum += term;
        end
        return sum;
    endfunction

    function automatic t_ppm_res predict_ppm(logic [11:0] adc);
        t_ppm_res r;
        longint unsigned a, s, num, den, g, p, ppm;
        longint lr, m, b, numer, e, f;
        a = 64'(adc) * vref_reg;
        s = 64'(supply_reg) << ADC_BITS;
        m = slope_reg;
        b = icept_reg;
        if (a <= (64'd10 << ADC_BITS) || r0_reg == 0) return '{32'd0, ST_LOW};
        if (m == 0) return '{32'hFFFF_FFFF, ST_SAT};
        num = (s > a) ? 64'(rl_reg) * (s - a) : 64'd0;
        den = a * r0_reg;
        if (num * 10 <= den) lr = -L10_Q20;
        else if (num >= den * 10) lr = L10_Q20;
        else lr = log2_fix(num) - log2_fix(den);
        numer = lr * 4096 - b * L10_Q20;
        e = numer / m;
        f = e + (64'sd8 << FRAC_BITS);
        if (f >= (64'sd32 << FRAC_BITS)) return '{32'hFFFF_FFFF, ST_SAT};
        if (f < -(64'sd1 << FRAC_BITS)) return '{32'd0, ST_OK};
        g = unsigned'(f + (64'sd1 << FRAC_BITS));
        p = pow2_frac(g & ((64'd1 << FRAC_BITS) - 1));
        ppm = ((p << (g >> FRAC_BITS)) + (64'd1 << 30)) >> 31;
        if (ppm > 64'hFFFF_FFFF) return '{32'hFFFF_FFFF, ST_SAT};
        r.ppm = ppm[31:0];
        r.status = ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Output side: random stalls, and a check on every accepted item.
    initial begin
        int stall;
        t_ppm_res want;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_valid && m_ready) begin
                if (pending_ppm.size() == 0) begin
                    report_mismatch("unexpected item", m_data, 0);
                end else begin
                    want = pending_ppm.pop_front();
                    if (m_data !== want.ppm) report_mismatch("ppm", m_data, want.ppm);
                    if (m_user !== want.status)
                        report_mismatch("status", 32'(m_user), 32'(want.status));
                end
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 7) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // The valid line stays high between items sent back to back.
    task automatic send_sample(logic [11:0] adc);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= IN_TDATA_W'(adc);
        pending_ppm.push_back(predict_ppm(adc));
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_ppm.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Registers change only once every earlier item has left the block.
    task automatic write_reg(t_cfg_idx idx, logic [23:0] val);
        s_valid <= 1'b0;
        while (pending_ppm.size() != 0) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_R0:     r0_reg = val;
            CFG_RL:     rl_reg = val;
            CFG_VREF:   vref_reg = val[12:0];
            CFG_SUPPLY: supply_reg = val[12:0];
            CFG_SLOPE:  slope_reg = val[15:0];
            default:    icept_reg = val[15:0];
        endcase
    endtask

    task automatic test_defaults();
        logic [11:0] edges[] = '{12'd0, 12'd12, 12'd13, 12'd14, 12'd1, 12'd4095,
                                 12'd2048, 12'd4094, 12'hAAA, 12'h555, 12'd100};
        foreach (edges[i]) send_sample(edges[i]);
        wait_drained();
    endtask

    task automatic test_special_settings();
        write_reg(CFG_R0, 24'd0);
        send_sample(12'd2000);
        write_reg(CFG_R0, 24'd1000);
        write_reg(CFG_SLOPE, 16'd0);
        send_sample(12'd2000);
        write_reg(CFG_SLOPE, 16'd1843);
        send_sample(12'd2000);
        send_sample(12'd100);
        write_reg(CFG_SLOPE, 16'h8000);
        write_reg(CFG_ICEPT, 16'h8000);
        send_sample(12'd3000);
        write_reg(CFG_ICEPT, 16'h7FFF);
        write_reg(CFG_SLOPE, 16'hFFFF);
        send_sample(12'd3000);
        write_reg(CFG_RL, 24'd0);
        send_sample(12'd1500);
        write_reg(CFG_RL, 24'hFFFFFF);
        write_reg(CFG_R0, 24'd1);
        write_reg(CFG_VREF, 13'd5000);
        write_reg(CFG_SUPPLY, 13'd1);
        send_sample(12'd4095);
        write_reg(CFG_SUPPLY, 13'h1FFF);
        write_reg(CFG_VREF, 13'd1);
        send_sample(12'd4095);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(CFG_R0, ($urandom_range(0, 9) == 0) ? 24'hFFFFFF
                                                          : 24'($urandom_range(1, 200000)));
            write_reg(CFG_RL, ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                          : 24'($urandom_range(1, 100000)));
            write_reg(CFG_VREF, ($urandom_range(0, 7) == 0) ? 13'($urandom)
                                                            : 13'($urandom_range(1, 5000)));
            write_reg(CFG_SUPPLY, ($urandom_range(0, 7) == 0) ? 13'($urandom)
                                                              : 13'($urandom_range(1, 5000)));
            write_reg(CFG_SLOPE, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                  : 16'(-$urandom_range(400, 8000)));
            write_reg(CFG_ICEPT, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                  : 16'($urandom_range(0, 16000) - 8000));
            if (ph == 8) calm = 1'b1;
            repeat (48) send_sample(12'($urandom));
            wait_drained();
        end
    endtask

    initial begin
        r0_reg = 24'd1000;
        rl_reg = 24'd10000;
        vref_reg = 13'd3300;
        supply_reg = 13'd3300;
        slope_reg = -16'sd1843;
        icept_reg = 16'sd4096;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_special_settings();
        test_random_settings();
        if (n_errors == 0 && pending_ppm.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
